// ===== hw/rtl/irs_pkg.sv =====
package irs_pkg;

    // Scan phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;

    // Input item opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CONV = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_CALIB_DIST = 2'd1;
    localparam logic [1:0] CFG_CALIB_INT  = 2'd2;

    // Configuration reset values.
    localparam logic       RST_ENABLED    = 1'b0;
    localparam logic [7:0] RST_CALIB_DIST = 8'd115;
    localparam logic [7:0] RST_CALIB_INT  = 8'd5;

    // Field widths and limits.
    localparam int        SAMPLE_W = 8;
    localparam int        DIST_W   = 20;
    localparam logic [19:0] DIST_MAX = 20'hFFFFF;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic div_step;
        logic sqrt_step;
        logic done;
    } t_dp_cmd;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic need_calc;
        logic out_valid;
    } t_dp_sts;

endpackage

// ===== hw/rtl/irs_ctrl.sv =====
module irs_ctrl
    import irs_pkg::*;
#(
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    localparam int NUM_W    = 24 + 2 * DIST_FRAC_BITS;
    localparam int SQ_STEPS = NUM_W / 2;
    localparam int CNT_W    = $clog2(NUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    // An item is taken only while idle and with the output slot free or draining.
    assign o_in_stall = (r_state != S_IDLE) || (i_sts.out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept && i_sts.need_calc) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/irs_dp.sv =====
module irs_dp
    import irs_pkg::*;
#(
    parameter int NUM_SENSORS    = 4,
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_opcode,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_emitter_on,
    output logic [1:0]          o_emitter_index,
    output logic                o_start_conversion,
    output logic                o_result_valid,
    output logic [1:0]          o_result_sensor,
    output logic [SAMPLE_W-1:0] o_result_reading,
    output logic [DIST_W-1:0]   o_result_distance,
    output logic                o_result_far
);

    localparam int IDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int NUM_W  = 24 + 2 * DIST_FRAC_BITS;
    localparam int ROOT_W = NUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int EXT_W  = ROOT_W + DIST_W;

    // Configuration registers.
    logic       r_enabled;
    logic [7:0] r_calib_dist;
    logic [7:0] r_calib_int;

    // Scan state.
    logic [1:0]          r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_ready, n_ready;
    logic [SAMPLE_W-1:0] r_latched, n_latched;

    // Arithmetic registers.
    logic [15:0]       r_prod1;
    logic [23:0]       num;
    logic [NUM_W-1:0]  r_divq;
    logic [7:0]        r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_sq_rem;

    // Output register.
    logic                r_out_valid;
    logic                r_emit_on;
    logic [1:0]          r_emit_idx;
    logic                r_start;
    logic                r_res_valid;
    logic [1:0]          r_res_sensor;
    logic [SAMPLE_W-1:0] r_res_reading;
    logic [DIST_W-1:0]   r_res_dist;
    logic                r_res_far;

    logic [1:0]       phase_cur;
    logic             start;
    logic             complete;
    logic             far;
    logic [IDX_W+1:0] idx_ext;
    logic [IDX_W:0]   idx_inc;
    logic [1:0]       idx2;

    logic [8:0]        div_t;
    logic              div_ge;
    logic [REM_W+1:0]  sq_cur;
    logic [REM_W+1:0]  sq_trial;
    logic              sq_ge;
    logic [EXT_W-1:0]  root_ext;
    logic [DIST_W-1:0] dist_sat;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= RST_ENABLED;
            r_calib_dist <= RST_CALIB_DIST;
            r_calib_int  <= RST_CALIB_INT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                CFG_CALIB_DIST: r_calib_dist <= i_cfg_data;
                CFG_CALIB_INT:  r_calib_int  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Scan sequencing for one item.
    always_comb begin
        phase_cur = ((r_phase == PH_WAIT) || (r_phase == PH_READ)) ? r_phase : PH_IDLE;
        n_phase   = phase_cur;
        n_idx     = r_idx;
        n_ready   = r_ready;
        n_latched = r_latched;
        start     = 1'b0;
        complete  = 1'b0;
        idx_inc   = {1'b0, r_idx} + 1'b1;
        if (i_opcode == OP_CONV) begin
            n_latched = i_sample;
            n_ready   = 1'b1;
        end else if (!r_enabled) begin
            n_phase = PH_IDLE;
        end else begin
            case (phase_cur)
                PH_IDLE: begin
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    start   = 1'b1;
                    n_phase = PH_READ;
                end
                PH_READ: begin
                    if (r_ready) begin
                        n_ready  = 1'b0;
                        n_phase  = PH_IDLE;
                        complete = 1'b1;
                        n_idx    = (idx_inc >= (IDX_W + 1)'(NUM_SENSORS)) ? '0
                                                                          : idx_inc[IDX_W-1:0];
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign idx_ext         = {2'b00, r_idx};
    assign idx2            = idx_ext[1:0];
    assign far             = (r_latched < SAMPLE_W'(2));
    assign o_sts.need_calc = complete && !far;
    assign o_sts.out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_idx     <= '0;
            r_ready   <= 1'b0;
            r_latched <= '0;
        end else if (i_cmd.accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_ready   <= n_ready;
            r_latched <= n_latched;
        end
    end

    // Full calibration product; it is scaled into the dividend on the second multiply step.
    assign num = r_prod1 * r_calib_dist;

    // Division step: one quotient bit per cycle, restoring.
    assign div_t  = {r_rem, r_divq[NUM_W-1]};
    assign div_ge = (div_t >= {1'b0, r_latched});

    // Square root step: one root bit per cycle from two quotient bits.
    assign sq_cur   = {r_sq_rem, r_divq[NUM_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_cur >= sq_trial);

    // Calibration product, then divide and root.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= r_calib_int * r_calib_dist;
        end
        if (i_cmd.mul2) begin
            r_divq   <= NUM_W'(num) << (2 * DIST_FRAC_BITS);
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? 8'(div_t - {1'b0, r_latched}) : div_t[7:0];
            r_divq <= {r_divq[NUM_W-2:0], div_ge};
        end else if (i_cmd.sqrt_step) begin
            r_sq_rem <= sq_ge ? REM_W'(sq_cur - sq_trial) : REM_W'(sq_cur);
            r_root   <= {r_root[ROOT_W-2:0], sq_ge};
            r_divq   <= r_divq << 2;
        end
    end

    // Saturate the root to the distance field.
    assign root_ext = EXT_W'(r_root);
    assign dist_sat = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

    // Output register; payload is written at accept, distance at the end of a measurement.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_emit_on     <= (n_phase != PH_IDLE);
            r_emit_idx    <= idx2;
            r_start       <= start;
            r_res_valid   <= complete;
            r_res_sensor  <= complete ? idx2 : 2'd0;
            r_res_reading <= complete ? r_latched : '0;
            r_res_far     <= complete && far;
            r_res_dist    <= '0;
        end else if (i_cmd.done) begin
            r_res_dist <= dist_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !o_sts.need_calc) || i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_emitter_on       = r_emit_on;
    assign o_emitter_index    = r_emit_idx;
    assign o_start_conversion = r_start;
    assign o_result_valid     = r_res_valid;
    assign o_result_sensor    = r_res_sensor;
    assign o_result_reading   = r_res_reading;
    assign o_result_distance  = r_res_dist;
    assign o_result_far       = r_res_far;

endmodule

// ===== hw/rtl/ir_range_sensor_scanner.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------
// input    | in        | i_in_valid / o_in_stall  | i_opcode, i_sample
// output   | out       | o_out_valid / i_out_stall| emitter, start, result fields
// config   | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// An item that completes no measurement, or one whose reading is below two, is
// registered at the output in the cycle it is accepted. A measuring item passes
// two multiply steps, a divide of 24 + 2*DIST_FRAC_BITS quotient bits and a square
// root of 12 + DIST_FRAC_BITS root bits in a shared shift-subtract datapath, then a
// load step. One item is in flight at a time; the next is taken once the sequencer
// is idle and the output register is free or being drained. Reset is synchronous
// and active low, with no clearing pass.
module ir_range_sensor_scanner
    import irs_pkg::*;
#(
    parameter int NUM_SENSORS    = 4,
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_emitter_on,
    output logic [1:0]          o_emitter_index,
    output logic                o_start_conversion,
    output logic                o_result_valid,
    output logic [1:0]          o_result_sensor,
    output logic [SAMPLE_W-1:0] o_result_reading,
    output logic [DIST_W-1:0]   o_result_distance,
    output logic                o_result_far,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    irs_ctrl #(
        .DIST_FRAC_BITS(DIST_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Scan state, arithmetic and output register.
    irs_dp #(
        .NUM_SENSORS   (NUM_SENSORS),
        .DIST_FRAC_BITS(DIST_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_sample          (i_sample),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_emitter_on      (o_emitter_on),
        .o_emitter_index   (o_emitter_index),
        .o_start_conversion(o_start_conversion),
        .o_result_valid    (o_result_valid),
        .o_result_sensor   (o_result_sensor),
        .o_result_reading  (o_result_reading),
        .o_result_distance (o_result_distance),
        .o_result_far      (o_result_far)
    );

endmodule
